FILE: rtl/tdpt_pkg.sv
// ---------------------------------------------------------------------------
// tdpt_pkg: shared constants and types for the trial division prime tester
// Holds the value width, the derived divisor and square widths, and the
// structs for the sequencer-divider handshake and the sequencer's result.
// ---------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_WIDTH = 16;
	// divisor reaches at most 2^ceil(VALUE_WIDTH/2), so one extra bit
	localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
	localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [DIV_WIDTH-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_rsp_t;

	typedef struct packed {
		logic                   valid;
		logic [VALUE_WIDTH-1:0] value;
		logic                   prime;
	} res_t;

endpackage

FILE: rtl/tdpt_divider.sv
// ---------------------------------------------------------------------------
// tdpt_divider: shared restoring remainder unit
// Brings in one dividend bit per cycle, MSB first, and keeps the partial
// remainder below the divisor. Raises done in the same cycle as the final remainder.
// ---------------------------------------------------------------------------
module tdpt_divider
	import tdpt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [DIV_WIDTH-1:0]   dvs_q;

	logic [DIV_WIDTH:0]     trial;
	logic [DIV_WIDTH-1:0]   diff;
	logic                   ge;
	logic [DIV_WIDTH-1:0]   rem_nxt;

	// one restoring step: shift in a bit, subtract the divisor if it fits
	always_comb begin
		trial   = {rem_q, dvd_q[VALUE_WIDTH-1]};
		ge      = trial >= {1'b0, dvs_q};
		// the difference is below the divisor whenever it is kept
		diff    = trial[DIV_WIDTH-1:0] - dvs_q;
		rem_nxt = ge ? diff : trial[DIV_WIDTH-1:0];
	end

	// control: load on start, count down the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/tdpt_seq.sv
// ---------------------------------------------------------------------------
// tdpt_seq: trial divisor sequencer
// Steps the divisor upward from two, keeps its square by running sums, and
// hands each trial to the shared divider until a factor or the bound is hit.
// ---------------------------------------------------------------------------
module tdpt_seq
	import tdpt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [VALUE_WIDTH-1:0] in_value,
	output logic                   in_ready,
	output div_req_t               div_req,
	input  div_rsp_t               div_rsp,
	output res_t                   res,
	input  logic                   res_take
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WAIT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [DIV_WIDTH-1:0]   d_q;
	logic [SQ_WIDTH-1:0]    sq_q;
	logic                   prime_q;
	logic                   start_q;

	// sequence the trials; square advances by 2d+1 with each divisor step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			d_q     <= '0;
			sq_q    <= '0;
			prime_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q  <= in_value;
						d_q  <= DIV_WIDTH'(2);
						sq_q <= SQ_WIDTH'(4);
						if (in_value < VALUE_WIDTH'(2)) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (sq_q > SQ_WIDTH'(n_q)) begin
						prime_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						start_q <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.rem_zero) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							d_q     <= d_q + DIV_WIDTH'(1);
							sq_q    <= sq_q + SQ_WIDTH'({d_q, 1'b1});
							state_q <= S_CHECK;
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign div_req.start    = start_q;
	assign div_req.dividend = n_q;
	assign div_req.divisor  = d_q;
	assign res.valid        = (state_q == S_DONE);
	assign res.value        = n_q;
	assign res.prime        = prime_q;

endmodule

FILE: rtl/trial_division_prime_test_unit.sv
// ---------------------------------------------------------------------------
// trial_division_prime_test_unit: iterative primality tester
// Tests each candidate word by trial division on one shared divider.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* takes one candidate word per transfer. Master
//   channel m_axis_* returns one word per candidate: the candidate echoed in
//   tdata and the prime flag in tuser.
//   Divisors run from two upward until a divisor leaves no remainder (not
//   prime) or its square exceeds the candidate (prime). Zero and one report
//   not prime without any trial.
//   Each trial runs the candidate through the shared restoring divider and
//   follows one bound check; for 16-bit values a candidate needs at most
//   254 trials. The divider's bit-per-cycle loop sets the time that each
//   trial takes.
//   s_axis_tready is high only while no candidate is in work. A finished
//   result moves into the output register; if the receiver stalls, the next
//   result waits in the sequencer until the register frees.
//   Reset (arst_n low) empties the block and drops any word in flight.
// ---------------------------------------------------------------------------
module trial_division_prime_test_unit
	import tdpt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_WIDTH-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] candidate
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_WIDTH-1:0] m_axis_tdata,  // [VALUE_WIDTH-1:0] tested_value
	output logic                   m_axis_tuser   // [0] is_prime
);

	div_req_t               div_req;
	div_rsp_t               div_rsp;
	res_t                   res;
	logic                   res_take;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_prime_q;

	tdpt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_value (s_axis_tdata[VALUE_WIDTH-1:0]),
		.in_ready (s_axis_tready),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.res      (res),
		.res_take (res_take)
	);

	tdpt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// take a result when the output register is empty or being drained
	assign res_take = res.valid && (!out_valid_q || m_axis_tready);

	// output register: hold the word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_value_q <= res.value;
			out_prime_q <= res.prime;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_WIDTH'(out_value_q);
	assign m_axis_tuser  = out_prime_q;

	// a candidate just taken closes the input in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready straight after accepting a candidate");

	// the divider finishes only while a candidate is in work
	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> !s_axis_tready)
		else $error("divider finished while the block was idle");

	// zero and one never leave flagged as prime
	a_prime_ge_two: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> out_value_q >= VALUE_WIDTH'(2))
		else $error("value below two flagged as prime");

	// the only even prime is two
	a_even_prime: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && !out_value_q[0] |-> out_value_q == VALUE_WIDTH'(2))
		else $error("even value above two flagged as prime");

endmodule

FILE: dv/tb_trial_division_prime_test_unit.sv
// ---------------------------------------------------------------------------
// tb_trial_division_prime_test_unit: self-checking bench for the prime tester
// Sends candidate words through the slave channel in random bursts, predicts
// each answer by its own trial division and checks every returned word, in
// order, against that prediction. The receiver stalls at random, holds off
// once for a long stretch so the block backs up, and the sender drains twice.
// ---------------------------------------------------------------------------
module tb_trial_division_prime_test_unit
	import tdpt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 120;
	localparam int unsigned HOLD_CYCLES  = 4000;
	localparam int unsigned HOLD_AT_SENT = 60;
	localparam int unsigned TAIL_CYCLES  = 6000;
	localparam int unsigned CYCLE_LIMIT  = 3000000;

	typedef struct {
		logic [VALUE_WIDTH-1:0] candidate;
		bit                     drain_first;
	} candidate_item_t;

	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		logic                   prime;
	} prime_answer_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_WIDTH-1:0] s_axis_tdata  = '0;  // [VALUE_WIDTH-1:0] candidate
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_WIDTH-1:0] m_axis_tdata;        // [VALUE_WIDTH-1:0] tested_value
	logic                   m_axis_tuser;        // [0] is_prime

	candidate_item_t pending_candidates[$];
	prime_answer_t   expected_answers[$];

	int unsigned candidates_sent = 0;
	int unsigned answers_checked = 0;
	int unsigned error_count     = 0;
	int unsigned cycle_count     = 0;

	trial_division_prime_test_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// trial division from two upward, stop once the divisor squared passes n
	function automatic logic prime_flag_of(input logic [VALUE_WIDTH-1:0] n);
		int unsigned d;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	task automatic queue_candidate(input logic [VALUE_WIDTH-1:0] n, input bit drain_first);
		candidate_item_t item;
		item.candidate   = n;
		item.drain_first = drain_first;
		pending_candidates.push_back(item);
	endtask

	// driver: offer words in bursts of random length with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin
		prime_answer_t answer;
		logic [VALUE_WIDTH-1:0] accepted;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			// record the word taken at this edge
			if (s_axis_tvalid && s_axis_tready) begin
				accepted     = s_axis_tdata[VALUE_WIDTH-1:0];
				answer.value = accepted;
				answer.prime = prime_flag_of(accepted);
				expected_answers.push_back(answer);
				candidates_sent <= candidates_sent + 1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the word on offer
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_candidates.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (pending_candidates[0].drain_first &&
					(candidates_sent + (s_axis_tvalid ? 1 : 0) != answers_checked)) begin
				// wait until every outstanding answer is back
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tdata  <= TDATA_WIDTH'(pending_candidates[0].candidate);
				s_axis_tvalid <= 1'b1;
				void'(pending_candidates.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
		end
	end

	// receiver: random stall pattern plus one long hold-off
	int unsigned ready_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (!hold_done && candidates_sent >= HOLD_AT_SENT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (ready_left > 0)
				ready_left--;
			if (ready_left == 0) begin
				ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
					: $urandom_range(1, 20);
				stall_left = $urandom_range(0, 8);
			end
		end
	end

	// monitor: check each returned word against the oldest prediction
	always @(posedge clk) begin
		prime_answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			answers_checked <= answers_checked + 1;
			if (expected_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected word value=%0d prime=%0b",
					m_axis_tdata[VALUE_WIDTH-1:0], m_axis_tuser));
			end else begin
				want = expected_answers.pop_front();
				if (m_axis_tdata[VALUE_WIDTH-1:0] !== want.value)
					report_mismatch($sformatf("tested_value got %0d want %0d",
						m_axis_tdata[VALUE_WIDTH-1:0], want.value));
				if (m_axis_tuser !== want.prime)
					report_mismatch($sformatf("is_prime of %0d got %0b want %0b",
						want.value, m_axis_tuser, want.prime));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned i;
		int unsigned p;
		logic [VALUE_WIDTH-1:0] n;

		// directed: ends of the range, small primes, squares, bit patterns
		queue_candidate(16'd0, 1'b0);
		queue_candidate(16'd1, 1'b0);
		queue_candidate(16'd2, 1'b0);
		queue_candidate(16'd3, 1'b0);
		queue_candidate(16'd4, 1'b0);
		queue_candidate(16'd5, 1'b0);
		queue_candidate(16'd9, 1'b0);
		queue_candidate(16'd25, 1'b0);
		queue_candidate(16'd49, 1'b0);
		queue_candidate(16'd256, 1'b0);
		queue_candidate(16'd257, 1'b0);
		queue_candidate(16'd32749, 1'b0);
		queue_candidate(16'd32768, 1'b0);
		queue_candidate(16'd63001, 1'b0);   // 251 squared
		queue_candidate(16'd65519, 1'b0);
		queue_candidate(16'd65521, 1'b0);   // largest 16-bit prime
		queue_candidate(16'd65534, 1'b0);
		queue_candidate(16'd65535, 1'b0);
		queue_candidate(16'h5555, 1'b0);
		queue_candidate(16'hAAAA, 1'b0);

		// random: small values, full range, upper odd values, squares
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: n = VALUE_WIDTH'($urandom_range(0, 300));
				4, 5, 6:    n = VALUE_WIDTH'($urandom);
				7:          n = VALUE_WIDTH'($urandom_range(49152, 65535)) | VALUE_WIDTH'(1);
				default: begin
					p = $urandom_range(2, 255);
					n = VALUE_WIDTH'(p * p);
				end
			endcase
			queue_candidate(n, (i == 0) || (i == RANDOM_ITEMS / 2));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain the stimulus and the answers, then idle for the tail
		while (pending_candidates.size() != 0 || s_axis_tvalid ||
				expected_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
